// ===== hdl/pfpd_pkg.sv =====
// Package for the page frame parser with debounce.
// Holds frame constants, the queue entry type, the front state type and the page decoder.
// No dependencies; every other file of the block imports it.
package pfpd_pkg;

    localparam logic [7:0]  SYNC_BYTE   = 8'h55;
    localparam logic [7:0]  HEADER_BYTE = 8'hAA;
    localparam logic [15:0] BAD_BITS    = 16'h8001;
    localparam logic [15:0] VALID_BIT   = 16'h4000;
    localparam logic [15:0] VALID_CLEAR = 16'hBFFF;
    localparam logic [1:0]  REPEATS     = 2'd3;
    localparam int          PAGE_W      = 14;
    localparam int          WORD_W      = 16;

    // Queue between front and back
    localparam int          Q_DEPTH     = 2;
    localparam int          Q_AW        = $clog2(Q_DEPTH);
    localparam int          Q_CW        = $clog2(Q_DEPTH + 1);

    // Collected-byte positions after sync
    localparam logic [1:0]  IDX_HDR     = 2'd0;
    localparam logic [1:0]  IDX_HI      = 2'd1;
    localparam logic [1:0]  IDX_LO      = 2'd2;

    typedef enum logic {
        FS_HUNT,
        FS_COLLECT
    } t_front_state;

    // One classified byte: a completed good frame carries its raw word
    typedef struct packed {
        logic              is_frame;
        logic [WORD_W-1:0] word;
    } t_q_entry;

    // Invert the word and pull the page out of it; 0 means invalid
    function automatic logic [PAGE_W-1:0] f_decode(logic [WORD_W-1:0] w, logic raw);
        logic [WORD_W-1:0] inv;
        logic [WORD_W-1:0] cleared;
        logic [PAGE_W-1:0] page;
        inv     = ~w;
        cleared = inv & VALID_CLEAR;
        page    = '0;
        if ((inv & BAD_BITS) != '0) begin
            page = '0;
        end else if (raw) begin
            page = inv[PAGE_W:1];
        end else if ((inv & VALID_BIT) != '0) begin
            page = cleared[PAGE_W:1];
        end
        return page;
    endfunction

endpackage

// ===== hdl/pfpd_if.sv =====
// Valid/ready channel interfaces for the page frame parser.
// Depends on pfpd_pkg for field widths.
interface pfpd_in_if import pfpd_pkg::*; ();
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface pfpd_out_if import pfpd_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              frame_done;
    logic [PAGE_W-1:0] page_value;
    logic              page_confirmed;
    logic              page_changed;

    modport source (output valid, output frame_done, output page_value,
                    output page_confirmed, output page_changed, input ready);
    modport sink   (input valid, input frame_done, input page_value,
                    input page_confirmed, input page_changed, output ready);
endinterface

// ===== hdl/pfpd_front.sv =====
// Front end: sync hunt and frame assembly, one byte per cycle while the queue is not full.
// Every accepted byte is pushed to the queue, tagged when it completes a good frame.
// Depends on pfpd_pkg and pfpd_in_if.
module pfpd_front import pfpd_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    pfpd_in_if.sink    i_rx,
    input  logic       i_q_full,
    output logic       o_push,
    output t_q_entry   o_entry
);

    t_front_state r_state, n_state;
    logic [1:0]   r_idx, n_idx;
    logic         r_hdr_ok;
    logic [7:0]   r_hi;
    logic         w_xfer;
    logic         w_last;

    assign i_rx.ready = ~i_q_full;
    assign w_xfer     = i_rx.valid & i_rx.ready;
    assign w_last     = (r_state == FS_COLLECT) && (r_idx == IDX_LO);

    // Next state
    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        if (w_xfer) begin
            case (r_state)
                FS_HUNT: begin
                    if (i_rx.rx_byte == SYNC_BYTE) begin
                        n_state = FS_COLLECT;
                        n_idx   = IDX_HDR;
                    end
                end
                FS_COLLECT: begin
                    if (r_idx == IDX_LO) begin
                        n_state = FS_HUNT;
                        n_idx   = IDX_HDR;
                    end else begin
                        n_idx = r_idx + 2'd1;
                    end
                end
                default: begin
                    n_state = FS_HUNT;
                    n_idx   = IDX_HDR;
                end
            endcase
        end
    end

    // Outputs: push every transfer, tag frame completion
    always_comb begin
        o_push           = w_xfer;
        o_entry.is_frame = w_last & r_hdr_ok;
        o_entry.word     = {r_hi, i_rx.rx_byte};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= FS_HUNT;
            r_idx   <= IDX_HDR;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
        end
    end

    // Frame bytes, no reset needed
    always_ff @(posedge i_clk) begin
        if (w_xfer && r_state == FS_COLLECT) begin
            if (r_idx == IDX_HDR) begin
                r_hdr_ok <= (i_rx.rx_byte == HEADER_BYTE);
            end
            if (r_idx == IDX_HI) begin
                r_hi <= i_rx.rx_byte;
            end
        end
    end

endmodule

// ===== hdl/pfpd_queue.sv =====
// Two-entry queue between front and back ends.
// Full is registered, so the front never sees the output-side ready.
// Depends on pfpd_pkg.
module pfpd_queue import pfpd_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_push,
    input  t_q_entry i_entry,
    input  logic     i_pop,
    output logic     o_valid,
    output logic     o_full,
    output t_q_entry o_entry
);

    t_q_entry        r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wr_ptr;
    logic [Q_AW-1:0] r_rd_ptr;
    logic [Q_CW-1:0] r_count;

    assign o_valid = (r_count != '0);
    assign o_full  = (r_count == Q_CW'(Q_DEPTH));
    assign o_entry = r_mem[r_rd_ptr];

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) r_wr_ptr <= r_wr_ptr + Q_AW'(1);
            if (i_pop)  r_rd_ptr <= r_rd_ptr + Q_AW'(1);
            r_count <= r_count + Q_CW'(i_push) - Q_CW'(i_pop);
        end
    end

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

endmodule

// ===== hdl/pfpd_back.sv =====
// Back end: page decode, repeat debounce and change detection.
// Pops one queue entry per cycle into the output register while it is empty or being taken.
// Depends on pfpd_pkg and pfpd_out_if.
module pfpd_back import pfpd_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_raw_mode,
    input  logic        i_q_valid,
    input  t_q_entry    i_q_entry,
    output logic        o_pop,
    pfpd_out_if.source  o_res
);

    logic [PAGE_W-1:0] r_cur, n_cur;
    logic [PAGE_W-1:0] r_cand, n_cand;
    logic [PAGE_W-1:0] r_rep, n_rep;
    logic [1:0]        r_tally, n_tally;
    logic              r_valid;
    logic              r_done, n_done;
    logic              r_conf, n_conf;
    logic              r_chg, n_chg;
    logic [PAGE_W-1:0] w_page;
    logic [1:0]        w_tally_inc;

    assign o_pop       = i_q_valid & (~r_valid | o_res.ready);
    assign w_page      = f_decode(i_q_entry.word, i_raw_mode);
    assign w_tally_inc = r_tally + 2'd1;

    // Page state update for one entry
    always_comb begin
        n_cur   = r_cur;
        n_cand  = r_cand;
        n_rep   = r_rep;
        n_tally = r_tally;
        n_done  = 1'b0;
        n_conf  = 1'b0;
        n_chg   = 1'b0;
        if (i_q_entry.is_frame) begin
            n_done = 1'b1;
            n_cur  = w_page;
            if (r_cand != w_page) begin
                n_cand  = w_page;
                n_tally = '0;
            end else if (w_tally_inc == REPEATS) begin
                n_tally = '0;
                n_conf  = 1'b1;
                n_chg   = (r_rep != w_page);
                n_rep   = w_page;
            end else begin
                n_tally = w_tally_inc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_cur   <= '0;
            r_cand  <= '0;
            r_rep   <= '0;
            r_tally <= '0;
        end else begin
            if (o_pop) begin
                r_valid <= 1'b1;
                r_cur   <= n_cur;
                r_cand  <= n_cand;
                r_rep   <= n_rep;
                r_tally <= n_tally;
            end else if (o_res.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    // Result flags, loaded with the state
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_done <= n_done;
            r_conf <= n_conf;
            r_chg  <= n_chg;
        end
    end

    assign o_res.valid          = r_valid;
    assign o_res.frame_done     = r_done;
    assign o_res.page_value     = r_cur;
    assign o_res.page_confirmed = r_conf;
    assign o_res.page_changed   = r_chg;

endmodule

// ===== hdl/page_frame_parser_debounce.sv =====
// Top level of the page frame parser with debounce.
// Depends on pfpd_pkg, pfpd_if, pfpd_front, pfpd_queue and pfpd_back.
//
//   channel   dir   handshake          payload
//   i_rx      in    valid / ready      rx_byte[7:0]
//   o_res     out   valid / ready      frame_done, page_value[13:0],
//                                      page_confirmed, page_changed
//   cfg       in    i_cfg_we           i_cfg_wdata = raw_mode
//
// One result per byte; a byte can transfer every cycle while the queue has room.
// Its result goes through the front push into the queue, then the back decode into
// the output register, and is valid once that register is loaded.
// Rate is set by the front, which takes one byte a cycle while the queue has room.
// Reset clears the hunt state, queue, page state and raw_mode; no clearing pass.
// A stall on o_res holds the output register; the two-entry queue absorbs it
// before i_rx.ready drops.
module page_frame_parser_debounce import pfpd_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata,
    pfpd_in_if.sink     i_rx,
    pfpd_out_if.source  o_res
);

    logic     r_raw_mode;
    logic     w_push;
    logic     w_pop;
    logic     w_q_valid;
    logic     w_q_full;
    t_q_entry w_push_entry;
    t_q_entry w_pop_entry;

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_raw_mode <= 1'b0;
        end else if (i_cfg_we) begin
            r_raw_mode <= i_cfg_wdata;
        end
    end

    pfpd_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_rx     (i_rx),
        .i_q_full (w_q_full),
        .o_push   (w_push),
        .o_entry  (w_push_entry)
    );

    pfpd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_entry (w_push_entry),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_full  (w_q_full),
        .o_entry (w_pop_entry)
    );

    pfpd_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_raw_mode (r_raw_mode),
        .i_q_valid  (w_q_valid),
        .i_q_entry  (w_pop_entry),
        .o_pop      (w_pop),
        .o_res      (o_res)
    );

endmodule

// ===== hdl/pfpd_chk.sv =====
// Port-level checker for the page frame parser, bound to the top level.
// Depends on pfpd_pkg for widths.
module pfpd_chk import pfpd_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_out_valid,
    input logic              i_out_ready,
    input logic              i_frame_done,
    input logic [PAGE_W-1:0] i_page_value,
    input logic              i_page_confirmed,
    input logic              i_page_changed
);

    // No result shows right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

    // Confirmation only on a decoded frame
    a_conf_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_page_confirmed |-> i_frame_done)
        else $error("page_confirmed without frame_done");

    // Change only on confirmation
    a_chg_conf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_page_changed |-> i_page_confirmed)
        else $error("page_changed without page_confirmed");

    // A stalled result holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_page_value)
            && $stable(i_frame_done) && $stable(i_page_confirmed)
            && $stable(i_page_changed))
        else $error("stalled result changed");

endmodule

bind page_frame_parser_debounce pfpd_chk u_pfpd_chk (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_out_valid      (o_res.valid),
    .i_out_ready      (o_res.ready),
    .i_frame_done     (o_res.frame_done),
    .i_page_value     (o_res.page_value),
    .i_page_confirmed (o_res.page_confirmed),
    .i_page_changed   (o_res.page_changed)
);
